@@ hw/rtl/nce_pkg.sv @@
// ----------------------------------------------------------------------------
// NURBS curve evaluator package
// Shared constants, payload types, control codes and port structs.
// ----------------------------------------------------------------------------
package nce_pkg;

  localparam int MAX_POINTS = 64;
  localparam int MAX_DEGREE = 7;
  localparam int FRAC_BITS  = 16;
  localparam int KNOT_DEPTH = MAX_POINTS + MAX_DEGREE + 1;

  localparam int COORD_W = 32;
  localparam int SLOT_W  = 7;
  localparam int CNT_W   = 7;
  localparam int CFG_IW  = 1;
  localparam int PT_AW   = $clog2(MAX_POINTS);
  localparam int KN_AW   = $clog2(KNOT_DEPTH);
  localparam int DEG_W   = $clog2(MAX_DEGREE + 1);
  localparam int HOM_W   = 2 * COORD_W - FRAC_BITS + 1;
  localparam int NUM_W   = HOM_W - 1;
  localparam int ALPHA_W = FRAC_BITS + 1;
  localparam int PROD_W  = HOM_W + ALPHA_W;
  localparam int QUO_W   = COORD_W;
  localparam int LANES   = 4;

  localparam logic [DEG_W-1:0] DEG_RESET = DEG_W'(3);

  typedef enum logic [CFG_IW-1:0] {
    CFG_DEGREE = 1'b0,
    CFG_COUNT  = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    REQ_POINT = 2'd0,
    REQ_KNOT  = 2'd1,
    REQ_EVAL  = 2'd2,
    REQ_NOP   = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_ZERO_W = 2'd1,
    STAT_NO_PTS = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLAMP,
    S_LAST,
    S_SRCH,
    S_LD_RD,
    S_LD_MUL,
    S_LD_WR,
    S_DB_RD,
    S_DB_KNOT,
    S_DB_DIV,
    S_DB_MUL,
    S_DB_WB,
    S_FN_RD,
    S_FN_CHK,
    S_FN_DIV,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
    logic [COORD_W-1:0] w;
  } point_t;

  // lanes: 0 x, 1 y, 2 z, 3 weight
  typedef logic [LANES-1:0][HOM_W-1:0] hom_t;

  typedef struct packed {
    logic               pt_we;
    logic [PT_AW-1:0]   pt_waddr;
    point_t             pt_wdata;
    logic [PT_AW-1:0]   pt_raddr;
    logic               kn_we;
    logic [KN_AW-1:0]   kn_waddr;
    logic [COORD_W-1:0] kn_wdata;
    logic [KN_AW-1:0]   kn_raddr_a;
    logic [KN_AW-1:0]   kn_raddr_b;
  } mem_req_t;

  typedef struct packed {
    point_t             pt_rdata;
    logic [COORD_W-1:0] kn_rdata_a;
    logic [COORD_W-1:0] kn_rdata_b;
  } mem_rsp_t;

  typedef struct packed {
    logic               start;
    logic [NUM_W-1:0]   num;
    logic [COORD_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quo;
  } div_rsp_t;

endpackage

@@ hw/rtl/nce_div.sv @@
// ----------------------------------------------------------------------------
// NURBS fixed-point divider
// Restoring radix-2 divider, one quotient bit per cycle: floor(num*ONE/den),
// valid when num/ONE is below den.
// ----------------------------------------------------------------------------
module nce_div import nce_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  localparam int CW = $clog2(QUO_W);

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [CW-1:0]      cnt_q, cnt_d;
  logic [COORD_W-1:0] rem_q, rem_d;
  logic [QUO_W-1:0]   quo_q, quo_d;
  logic [COORD_W-1:0] den_q, den_d;
  logic [COORD_W:0]   trial;
  logic [COORD_W:0]   sub;

  always_comb begin
    trial  = {rem_q, quo_q[QUO_W-1]};
    sub    = trial - {1'b0, den_q};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = req_i.num[NUM_W-1:FRAC_BITS];
      quo_d  = {req_i.num[FRAC_BITS-1:0], {(QUO_W-FRAC_BITS){1'b0}}};
      den_d  = req_i.den;
    end else if (busy_q) begin
      if (!sub[COORD_W]) begin
        rem_d = sub[COORD_W-1:0];
        quo_d = {quo_q[QUO_W-2:0], 1'b1};
      end else begin
        rem_d = trial[COORD_W-1:0];
        quo_d = {quo_q[QUO_W-2:0], 1'b0};
      end
      cnt_d = cnt_q + CW'(1);
      if (cnt_q == CW'(QUO_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;

endmodule

@@ hw/rtl/nce_store.sv @@
// ----------------------------------------------------------------------------
// NURBS control point and knot store
// Point memory (x, y, z, weight) with one read port and knot memory with two
// read ports; registered reads. Writes only occur while no evaluation runs.
// ----------------------------------------------------------------------------
module nce_store import nce_pkg::*; (
  input  logic     clk_i,
  input  mem_req_t req_i,
  output mem_rsp_t rsp_o
);

  point_t             pt_mem [MAX_POINTS];
  logic [COORD_W-1:0] kn_mem [KNOT_DEPTH];
  point_t             pt_rdata_q;
  logic [COORD_W-1:0] kn_rdata_a_q;
  logic [COORD_W-1:0] kn_rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (req_i.pt_we) begin
      pt_mem[req_i.pt_waddr] <= req_i.pt_wdata;
    end
    pt_rdata_q <= pt_mem[req_i.pt_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (req_i.kn_we) begin
      kn_mem[req_i.kn_waddr] <= req_i.kn_wdata;
    end
    kn_rdata_a_q <= kn_mem[req_i.kn_raddr_a];
    kn_rdata_b_q <= kn_mem[req_i.kn_raddr_b];
  end

  assign rsp_o.pt_rdata   = pt_rdata_q;
  assign rsp_o.kn_rdata_a = kn_rdata_a_q;
  assign rsp_o.kn_rdata_b = kn_rdata_b_q;

endmodule

@@ hw/rtl/nurbs_curve_3d_evaluator.sv @@
// ----------------------------------------------------------------------------
// NURBS curve 3D evaluator
// Rational de Boor evaluation over stored control points and knots.
// Point/knot write or no-op: the beat goes straight to S_DONE and the result is
// registered on the output once the output is free. Evaluation: clamp, span
// search (one knot per cycle), load of p+1 weighted points, p*(p+1)/2 lerps
// (serial divide for alpha unless it is 0 or 1), then a perspective divide per
// coordinate. One item at a time; a new beat is taken while a result waits on
// the output. Reset: degree 3, no points, stores undefined until written.
// ----------------------------------------------------------------------------
module nurbs_curve_3d_evaluator import nce_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [CFG_IW-1:0]         cfg_idx_i,
  input  logic [CNT_W-1:0]          cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [1:0]                req_type_i,
  input  logic [SLOT_W-1:0]         slot_i,
  input  logic signed [COORD_W-1:0] coord_x_i,
  input  logic signed [COORD_W-1:0] coord_y_i,
  input  logic signed [COORD_W-1:0] coord_z_i,
  input  logic [COORD_W-1:0]        point_weight_i,
  input  logic [COORD_W-1:0]        param_value_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic signed [COORD_W-1:0] out_x_o,
  output logic signed [COORD_W-1:0] out_y_o,
  output logic signed [COORD_W-1:0] out_z_o,
  output logic [1:0]                status_o
);

  localparam logic [COORD_W-1:0] SAT_POS = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic [COORD_W-1:0] SAT_NEG = {1'b1, {(COORD_W-1){1'b0}}};
  localparam logic [ALPHA_W-1:0] ONE_Q   = {1'b1, {FRAC_BITS{1'b0}}};
  localparam int                 HA_W    = $clog2(MAX_DEGREE + 1);

  function automatic logic [COORD_W-1:0] sat_q(input logic neg, input logic ovf,
                                               input logic [QUO_W-1:0] q);
    logic [COORD_W-1:0] r;
    if (!neg) begin
      r = (ovf || q[QUO_W-1]) ? SAT_POS : q;
    end else begin
      r = (ovf || q > SAT_NEG) ? SAT_NEG : (~q + COORD_W'(1));
    end
    return r;
  endfunction

  state_e state_q, state_d;
  logic [DEG_W-1:0]   degree_q;
  logic [CNT_W-1:0]   count_q;
  logic               out_valid_q, out_valid_d;
  logic               load_out;
  logic               acc;

  logic [CNT_W-1:0]   cnt_c;
  logic [PT_AW-1:0]   n_c;
  logic [DEG_W-1:0]   p_c;

  logic [DEG_W-1:0]   p_q, p_d;
  logic [PT_AW-1:0]   n_q, n_d;
  logic [COORD_W-1:0] t_q, t_d;
  logic [KN_AW-1:0]   kidx_q, kidx_d;
  logic [PT_AW-1:0]   base_q, base_d;
  logic [DEG_W-1:0]   j_q, j_d;
  logic [DEG_W-1:0]   r_q, r_d;
  logic [1:0]         comp_q, comp_d;
  logic [ALPHA_W-1:0] alpha_q, alpha_d;
  hom_t               ha_q, ha_d;
  hom_t               hb_q, hb_d;
  logic [PROD_W-1:0]  prod_q [LANES];
  logic [PROD_W-1:0]  prod_d [LANES];
  logic [LANES-1:0]   neg_q, neg_d;
  logic               fneg_q, fneg_d;
  logic [COORD_W-1:0] res_q [3];
  logic [COORD_W-1:0] res_d [3];
  logic [1:0]         stat_q, stat_d;
  logic [COORD_W-1:0] out_x_q, out_y_q, out_z_q;
  logic [1:0]         out_stat_q;

  hom_t               h_q [MAX_DEGREE+1];
  logic               h_we;
  logic [HA_W-1:0]    h_waddr;
  hom_t               h_wdata;
  logic [HA_W-1:0]    h_raddr;
  hom_t               h_rdata;

  mem_req_t           mreq;
  mem_rsp_t           mrsp;
  div_req_t           dreq;
  div_rsp_t           drsp;

  logic [COORD_W-1:0] tc;
  logic [KN_AW-1:0]   kn_a;
  logic [COORD_W:0]   anum, aden;
  logic [COORD_W-1:0] amag_n, amag_d;
  logic               a_zero, a_full;
  logic [HOM_W-1:0]   fw, fc, fmag;
  logic               fwpos, fovf;
  logic [HOM_W:0]     diff_c [LANES];
  logic [HOM_W-1:0]   dmag_c [LANES];
  logic [COORD_W-1:0] cmag_c [3];
  logic [HOM_W-1:0]   sh_c   [LANES];
  hom_t               wb_c;
  logic               wb_base;

  assign in_ready_o = (state_q == S_IDLE);
  assign acc        = in_valid_i && in_ready_o;

  // effective count, last index and degree
  always_comb begin
    cnt_c = (count_q > CNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS) : count_q;
    n_c   = PT_AW'(cnt_c - CNT_W'(1));
    p_c   = ({{(PT_AW-DEG_W){1'b0}}, degree_q} > n_c) ? n_c[DEG_W-1:0] : degree_q;
  end

  assign h_rdata = h_q[h_raddr];

  nce_store u_store (
    .clk_i (clk_i),
    .req_i (mreq),
    .rsp_o (mrsp)
  );

  nce_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (dreq),
    .rsp_o  (drsp)
  );

  // lane arithmetic
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      diff_c[i] = {hb_q[i][HOM_W-1], hb_q[i]} - {ha_q[i][HOM_W-1], ha_q[i]};
      dmag_c[i] = diff_c[i][HOM_W] ? HOM_W'(~diff_c[i] + 1'b1) : diff_c[i][HOM_W-1:0];
      sh_c[i]   = prod_q[i][FRAC_BITS +: HOM_W];
      wb_c[i]   = (wb_base ? ha_q[i] : '0) + (neg_q[i] ? (~sh_c[i] + 1'b1) : sh_c[i]);
    end
    cmag_c[0] = mrsp.pt_rdata.x[COORD_W-1] ? (~mrsp.pt_rdata.x + 1'b1) : mrsp.pt_rdata.x;
    cmag_c[1] = mrsp.pt_rdata.y[COORD_W-1] ? (~mrsp.pt_rdata.y + 1'b1) : mrsp.pt_rdata.y;
    cmag_c[2] = mrsp.pt_rdata.z[COORD_W-1] ? (~mrsp.pt_rdata.z + 1'b1) : mrsp.pt_rdata.z;
  end

  // knot interval ratio and final divide checks
  always_comb begin
    anum   = {1'b0, t_q} - {1'b0, mrsp.kn_rdata_a};
    aden   = {1'b0, mrsp.kn_rdata_b} - {1'b0, mrsp.kn_rdata_a};
    amag_n = anum[COORD_W] ? COORD_W'(~anum + 1'b1) : anum[COORD_W-1:0];
    amag_d = aden[COORD_W] ? COORD_W'(~aden + 1'b1) : aden[COORD_W-1:0];
    a_zero = (aden == '0) || (anum == '0) || (anum[COORD_W] != aden[COORD_W]);
    a_full = (amag_n >= amag_d);
    fw     = hb_q[3];
    fwpos  = !fw[HOM_W-1] && (fw != '0);
    fc     = hb_q[comp_q];
    fmag   = fc[HOM_W-1] ? (~fc + 1'b1) : fc;
    fovf   = (fmag[NUM_W-1:FRAC_BITS] >= fw[COORD_W-1:0]);
    tc     = (t_q > mrsp.kn_rdata_b) ? mrsp.kn_rdata_b : t_q;
    tc     = (tc < mrsp.kn_rdata_a) ? mrsp.kn_rdata_a : tc;
    kn_a   = KN_AW'(base_q) + KN_AW'(j_q);
  end

  always_comb begin
    state_d  = state_q;
    p_d      = p_q;
    n_d      = n_q;
    t_d      = t_q;
    kidx_d   = kidx_q;
    base_d   = base_q;
    j_d      = j_q;
    r_d      = r_q;
    comp_d   = comp_q;
    alpha_d  = alpha_q;
    ha_d     = ha_q;
    hb_d     = hb_q;
    prod_d   = prod_q;
    neg_d    = neg_q;
    fneg_d   = fneg_q;
    res_d    = res_q;
    stat_d   = stat_q;
    load_out = 1'b0;
    h_we     = 1'b0;
    h_waddr  = j_q;
    h_wdata  = wb_c;
    h_raddr  = j_q;
    wb_base  = 1'b0;

    mreq            = '0;
    mreq.pt_we      = acc && (req_type_i == REQ_POINT) && (slot_i < SLOT_W'(MAX_POINTS));
    mreq.pt_waddr   = slot_i[PT_AW-1:0];
    mreq.pt_wdata   = '{x: coord_x_i, y: coord_y_i, z: coord_z_i, w: point_weight_i};
    mreq.kn_we      = acc && (req_type_i == REQ_KNOT) && (slot_i < SLOT_W'(KNOT_DEPTH));
    mreq.kn_waddr   = slot_i[KN_AW-1:0];
    mreq.kn_wdata   = param_value_i;
    mreq.pt_raddr   = PT_AW'(base_q + PT_AW'(j_q));
    mreq.kn_raddr_a = KN_AW'(p_c);
    mreq.kn_raddr_b = KN_AW'(cnt_c);

    dreq.start = 1'b0;
    dreq.num   = NUM_W'(amag_n);
    dreq.den   = amag_d;

    unique case (state_q)
      S_IDLE: begin
        if (acc) begin
          t_d    = param_value_i;
          p_d    = p_c;
          n_d    = n_c;
          stat_d = STAT_OK;
          for (int i = 0; i < 3; i++) res_d[i] = '0;
          if (req_type_i == REQ_EVAL) begin
            if (cnt_c == '0) begin
              stat_d  = STAT_NO_PTS;
              state_d = S_DONE;
            end else begin
              state_d = S_CLAMP;
            end
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_CLAMP: begin
        t_d = tc;
        if (tc >= mrsp.kn_rdata_b) begin
          mreq.pt_raddr = n_q;
          state_d       = S_LAST;
        end else begin
          mreq.kn_raddr_a = KN_AW'(p_q) + KN_AW'(1);
          kidx_d          = KN_AW'(p_q) + KN_AW'(1);
          state_d         = S_SRCH;
        end
      end
      S_LAST: begin
        res_d[0] = mrsp.pt_rdata.x;
        res_d[1] = mrsp.pt_rdata.y;
        res_d[2] = mrsp.pt_rdata.z;
        state_d  = S_DONE;
      end
      S_SRCH: begin
        mreq.kn_raddr_a = kidx_q + KN_AW'(1);
        if (t_q < mrsp.kn_rdata_a) begin
          base_d  = PT_AW'(kidx_q - KN_AW'(1) - KN_AW'(p_q));
          j_d     = '0;
          state_d = S_LD_RD;
        end else begin
          kidx_d = kidx_q + KN_AW'(1);
        end
      end
      S_LD_RD: begin
        state_d = S_LD_MUL;
      end
      S_LD_MUL: begin
        for (int i = 0; i < 3; i++) begin
          prod_d[i] = PROD_W'(cmag_c[i] * mrsp.pt_rdata.w);
        end
        prod_d[3] = PROD_W'({mrsp.pt_rdata.w, {FRAC_BITS{1'b0}}});
        neg_d     = {1'b0, mrsp.pt_rdata.z[COORD_W-1], mrsp.pt_rdata.y[COORD_W-1],
                     mrsp.pt_rdata.x[COORD_W-1]};
        state_d   = S_LD_WR;
      end
      S_LD_WR: begin
        h_we = 1'b1;
        if (j_q == p_q) begin
          if (p_q == '0) begin
            state_d = S_FN_RD;
          end else begin
            r_d     = DEG_W'(1);
            j_d     = p_q;
            state_d = S_DB_RD;
          end
        end else begin
          j_d     = j_q + DEG_W'(1);
          state_d = S_LD_RD;
        end
      end
      S_DB_RD: begin
        mreq.kn_raddr_a = kn_a;
        mreq.kn_raddr_b = kn_a + KN_AW'(p_q) - KN_AW'(r_q) + KN_AW'(1);
        hb_d            = h_rdata;
        state_d         = S_DB_KNOT;
      end
      S_DB_KNOT: begin
        h_raddr = j_q - DEG_W'(1);
        ha_d    = h_rdata;
        if (a_zero) begin
          alpha_d = '0;
          state_d = S_DB_MUL;
        end else if (a_full) begin
          alpha_d = ONE_Q;
          state_d = S_DB_MUL;
        end else begin
          dreq.start = 1'b1;
          state_d    = S_DB_DIV;
        end
      end
      S_DB_DIV: begin
        if (drsp.done) begin
          alpha_d = drsp.quo[ALPHA_W-1:0];
          state_d = S_DB_MUL;
        end
      end
      S_DB_MUL: begin
        for (int i = 0; i < LANES; i++) begin
          prod_d[i] = PROD_W'(dmag_c[i] * alpha_q);
          neg_d[i]  = diff_c[i][HOM_W];
        end
        state_d = S_DB_WB;
      end
      S_DB_WB: begin
        wb_base = 1'b1;
        h_we    = 1'b1;
        if (j_q == r_q) begin
          if (r_q == p_q) begin
            state_d = S_FN_RD;
          end else begin
            r_d     = r_q + DEG_W'(1);
            j_d     = p_q;
            state_d = S_DB_RD;
          end
        end else begin
          j_d     = j_q - DEG_W'(1);
          state_d = S_DB_RD;
        end
      end
      S_FN_RD: begin
        h_raddr = p_q;
        hb_d    = h_rdata;
        comp_d  = '0;
        state_d = S_FN_CHK;
      end
      S_FN_CHK: begin
        dreq.num = fmag[NUM_W-1:0];
        dreq.den = fw[COORD_W-1:0];
        if (!fwpos) begin
          for (int i = 0; i < 3; i++) res_d[i] = '0;
          stat_d  = STAT_ZERO_W;
          state_d = S_DONE;
        end else if (fovf) begin
          res_d[comp_q] = sat_q(fc[HOM_W-1], 1'b1, '0);
          if (comp_q == 2'd2) begin
            state_d = S_DONE;
          end else begin
            comp_d = comp_q + 2'd1;
          end
        end else begin
          dreq.start = 1'b1;
          fneg_d     = fc[HOM_W-1];
          state_d    = S_FN_DIV;
        end
      end
      S_FN_DIV: begin
        if (drsp.done) begin
          res_d[comp_q] = sat_q(fneg_q, 1'b0, drsp.quo);
          if (comp_q == 2'd2) begin
            state_d = S_DONE;
          end else begin
            comp_d  = comp_q + 2'd1;
            state_d = S_FN_CHK;
          end
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    out_valid_d = (out_valid_q && !out_ready_i) || load_out;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      degree_q    <= DEG_RESET;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i && cfg_idx_i == CFG_DEGREE) begin
        degree_q <= cfg_wdata_i[DEG_W-1:0];
      end
      if (cfg_we_i && cfg_idx_i == CFG_COUNT) begin
        count_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    p_q     <= p_d;
    n_q     <= n_d;
    t_q     <= t_d;
    kidx_q  <= kidx_d;
    base_q  <= base_d;
    j_q     <= j_d;
    r_q     <= r_d;
    comp_q  <= comp_d;
    alpha_q <= alpha_d;
    ha_q    <= ha_d;
    hb_q    <= hb_d;
    prod_q  <= prod_d;
    neg_q   <= neg_d;
    fneg_q  <= fneg_d;
    res_q   <= res_d;
    stat_q  <= stat_d;
    if (h_we) begin
      h_q[h_waddr] <= h_wdata;
    end
    if (load_out) begin
      out_x_q    <= res_q[0];
      out_y_q    <= res_q[1];
      out_z_q    <= res_q[2];
      out_stat_q <= stat_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_x_o     = out_x_q;
  assign out_y_o     = out_y_q;
  assign out_z_o     = out_z_q;
  assign status_o    = out_stat_q;

endmodule

@@ hw/rtl/nce_chk.sv @@
// ----------------------------------------------------------------------------
// NURBS evaluator port checker
// Port-level properties of the evaluator, bound to the top level.
// ----------------------------------------------------------------------------
module nce_chk import nce_pkg::*; (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      cfg_we_i,
  input logic [CFG_IW-1:0]         cfg_idx_i,
  input logic [CNT_W-1:0]          cfg_wdata_i,
  input logic                      in_valid_i,
  input logic                      in_ready_o,
  input logic [1:0]                req_type_i,
  input logic [SLOT_W-1:0]         slot_i,
  input logic signed [COORD_W-1:0] coord_x_i,
  input logic signed [COORD_W-1:0] coord_y_i,
  input logic signed [COORD_W-1:0] coord_z_i,
  input logic [COORD_W-1:0]        point_weight_i,
  input logic [COORD_W-1:0]        param_value_i,
  input logic                      out_valid_o,
  input logic                      out_ready_i,
  input logic signed [COORD_W-1:0] out_x_o,
  input logic signed [COORD_W-1:0] out_y_o,
  input logic signed [COORD_W-1:0] out_z_o,
  input logic [1:0]                status_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_x_o) && $stable(out_y_o)
      && $stable(out_z_o) && $stable(status_o))
    else $error("output beat changed while stalled");

  a_err_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != STAT_OK |-> out_x_o == '0 && out_y_o == '0 && out_z_o == '0)
    else $error("error status with nonzero point");

  a_one_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second beat taken while busy");

  a_write_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && req_type_i != REQ_EVAL && !out_valid_o |=> ##1 out_valid_o)
    else $error("write acknowledge late");

endmodule

bind nurbs_curve_3d_evaluator nce_chk u_nce_chk (.*);

@@ sim/testbench.sv @@
// ----------------------------------------------------------------------------
// NURBS curve evaluator testbench
// Loads control points and knots, sweeps degree and point count settings and
// evaluates the curve at random parameters. Every result beat is checked
// field by field against a cycle-free model of the rational de Boor evaluation.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import nce_pkg::*;

  typedef struct packed {
    req_e      req;
    bit [6:0]  slot;
    bit [31:0] x;
    bit [31:0] y;
    bit [31:0] z;
    bit [31:0] w;
    bit [31:0] t;
  } beat_t;

  typedef struct packed {
    bit [31:0] x;
    bit [31:0] y;
    bit [31:0] z;
    bit [1:0]  st;
  } point_res_t;

  localparam longint ONE = 64'd1 << FRAC_BITS;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  cfg_idx_e cfg_idx_i = CFG_DEGREE;
  logic [CNT_W-1:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic out_ready_i = 1'b0;
  beat_t beat = '0;
  logic in_ready_o, out_valid_o;
  logic signed [31:0] out_x_o, out_y_o, out_z_o;
  logic [1:0] status_o;

  // shadow of the block state
  bit [31:0] sx [MAX_POINTS];
  bit [31:0] sy [MAX_POINTS];
  bit [31:0] sz [MAX_POINTS];
  bit [31:0] sw [MAX_POINTS];
  bit [31:0] sk [KNOT_DEPTH];
  int unsigned cur_degree = 3;
  int unsigned cur_count = 0;

  beat_t pending_beats[$];
  point_res_t expected_points[$];
  int mismatches = 0;
  int idle_mode = 0;
  logic hold_go = 1'b0;
  logic hold_used = 1'b0;
  int hold_cnt = 0;

  nurbs_curve_3d_evaluator dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_o,
    .req_type_i(beat.req), .slot_i(beat.slot),
    .coord_x_i(beat.x), .coord_y_i(beat.y), .coord_z_i(beat.z),
    .point_weight_i(beat.w), .param_value_i(beat.t),
    .out_valid_o, .out_ready_i, .out_x_o, .out_y_o, .out_z_o, .status_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic longint scale_q(longint v, longint unsigned f);
    longint unsigned m, r;
    m = (v < 0) ? -v : v;
    r = (m >> FRAC_BITS) * f + (((m & (ONE - 1)) * f) >> FRAC_BITS);
    return (v < 0) ? -longint'(r) : longint'(r);
  endfunction

  function automatic longint div_q(longint num, longint unsigned den);
    longint unsigned m, q, r, res;
    m = (num < 0) ? -num : num;
    q = m / den;
    r = m % den;
    if (q >= 64'd1 << 32) res = 64'd1 << 40;
    else res = q * ONE + (r * ONE) / den;
    if (num < 0) return (res > 64'd2147483648) ? -64'sd2147483648 : -longint'(res);
    return (res > 64'd2147483647) ? 64'sd2147483647 : longint'(res);
  endfunction

  function automatic point_res_t curve_point(bit [31:0] t_in);
    point_res_t res;
    int unsigned c, n, p, k, idx;
    longint unsigned t, tmin, tmax, wgt;
    longint hx[8], hy[8], hz[8], hw[8];
    longint lo, den, a;
    bit found;
    res = '0;
    c = (cur_count > MAX_POINTS) ? MAX_POINTS : cur_count;
    if (c == 0) begin
      res.st = STAT_NO_PTS;
      return res;
    end
    n = c - 1;
    p = (cur_degree > n) ? n : cur_degree;
    tmin = sk[p];
    tmax = sk[c];
    t = t_in;
    if (t > tmax) t = tmax;
    if (t < tmin) t = tmin;
    if (t >= tmax) begin
      res.x = sx[n];
      res.y = sy[n];
      res.z = sz[n];
      return res;
    end
    k = n;
    found = 0;
    for (int unsigned j = p; j <= n; j++) begin
      if (!found && t < sk[j+1]) begin
        k = j;
        found = 1;
      end
    end
    for (int unsigned j = 0; j <= p; j++) begin
      idx = k - p + j;
      wgt = sw[idx];
      hx[j] = scale_q(longint'(signed'(sx[idx])), wgt);
      hy[j] = scale_q(longint'(signed'(sy[idx])), wgt);
      hz[j] = scale_q(longint'(signed'(sz[idx])), wgt);
      hw[j] = longint'(wgt);
    end
    for (int unsigned r = 1; r <= p; r++) begin
      for (int j = p; j >= int'(r); j--) begin
        idx = k - p + j;
        lo = longint'(sk[idx]);
        den = longint'(sk[idx + p + 1 - r]) - lo;
        a = 0;
        if (den != 0) begin
          a = (longint'(t) - lo) * ONE / den;
          if (a < 0) a = 0;
          if (a > ONE) a = ONE;
        end
        hx[j] = hx[j-1] + scale_q(hx[j] - hx[j-1], a);
        hy[j] = hy[j-1] + scale_q(hy[j] - hy[j-1], a);
        hz[j] = hz[j-1] + scale_q(hz[j] - hz[j-1], a);
        hw[j] = hw[j-1] + scale_q(hw[j] - hw[j-1], a);
      end
    end
    if (hw[p] <= 0) begin
      res.st = STAT_ZERO_W;
    end else begin
      res.x = 32'(div_q(hx[p], hw[p]));
      res.y = 32'(div_q(hy[p], hw[p]));
      res.z = 32'(div_q(hz[p], hw[p]));
    end
    return res;
  endfunction

  function automatic point_res_t apply_beat(beat_t b);
    point_res_t res;
    res = '0;
    case (b.req)
      REQ_POINT: begin
        if (b.slot < MAX_POINTS) begin
          sx[b.slot] = b.x;
          sy[b.slot] = b.y;
          sz[b.slot] = b.z;
          sw[b.slot] = b.w;
        end
      end
      REQ_KNOT: begin
        if (b.slot < KNOT_DEPTH) sk[b.slot] = b.t;
      end
      REQ_EVAL: res = curve_point(b.t);
      default: ;
    endcase
    return res;
  endfunction

  function automatic bit idle_now(bit sender);
    int unsigned pct;
    pct = (idle_mode == 2) ? 0 : ((idle_mode == 0) == sender) ? 36 : 57;
    return $urandom_range(99, 0) < pct;
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o)
        expected_points.insert(expected_points.size(), apply_beat(beat));
      if (!in_valid_i || in_ready_o) begin
        if (pending_beats.size() > 0 && !idle_now(1)) begin
          beat <= pending_beats.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver stalls, including one long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_cnt != 0) begin
      out_ready_i <= 1'b0;
      hold_cnt <= hold_cnt - 1;
    end else if (hold_go && !hold_used) begin
      out_ready_i <= 1'b0;
      hold_cnt <= 3000;
      hold_used <= 1'b1;
    end else begin
      out_ready_i <= !idle_now(0);
    end
  end

  // monitor
  always @(posedge clk_i) begin
    point_res_t exp_r;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_points.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat x=%h", out_x_o);
      end else begin
        exp_r = expected_points.pop_front();
        if (out_x_o !== exp_r.x || out_y_o !== exp_r.y || out_z_o !== exp_r.z ||
            status_o !== exp_r.st) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp %h %h %h st %0d, got %h %h %h st %0d",
                     exp_r.x, exp_r.y, exp_r.z, exp_r.st,
                     out_x_o, out_y_o, out_z_o, status_o);
        end
      end
    end
  end

  task automatic push(req_e r, int slot, bit [31:0] x, bit [31:0] y, bit [31:0] z,
                      bit [31:0] w, bit [31:0] t);
    beat_t b;
    b.req = r;
    b.slot = 7'(slot);
    b.x = x;
    b.y = y;
    b.z = z;
    b.w = w;
    b.t = t;
    pending_beats.insert(pending_beats.size(), b);
  endtask

  task automatic drain();
    while (pending_beats.size() != 0 || in_valid_i || expected_points.size() != 0)
      @(posedge clk_i);
    repeat (5) @(posedge clk_i);
  endtask

  task automatic cfg_write(cfg_idx_e idx, int unsigned val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= CNT_W'(val);
    if (idx == CFG_DEGREE) cur_degree = val & 7;
    else cur_count = val & 127;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic bit [31:0] rand_weight();
    case ($urandom_range(9, 0))
      0: return $urandom();
      1: return 32'h0;
      default: return $urandom_range(32'h40000, 32'h4000);
    endcase
  endfunction

  task automatic run_phase(int unsigned deg, int unsigned cnt, int n_eval, bit hold);
    bit [31:0] kv[KNOT_DEPTH];
    int unsigned c, p;
    bit [31:0] lo, hi, t;
    drain();
    cfg_write(CFG_DEGREE, deg);
    cfg_write(CFG_COUNT, cnt);
    if (hold) begin
      @(posedge clk_i);
      hold_go <= 1'b1;
    end
    c = (cnt > MAX_POINTS) ? MAX_POINTS : cnt;
    p = (c == 0) ? 0 : (deg > c - 1) ? c - 1 : deg;
    kv[0] = $urandom_range(32'h30000, 0);
    for (int i = 1; i < KNOT_DEPTH; i++)
      kv[i] = kv[i-1] + (($urandom_range(3, 0) == 0) ? 0 : $urandom_range(32'h30000, 1));
    for (int i = 0; i <= c + deg && i < KNOT_DEPTH; i++)
      push(REQ_KNOT, i, $urandom(), $urandom(), $urandom(), $urandom(), kv[i]);
    for (int i = 0; i < c; i++)
      push(REQ_POINT, i, $urandom(), $urandom(), $urandom(), rand_weight(), $urandom());
    lo = kv[p];
    hi = kv[c];
    for (int i = 0; i < n_eval; i++) begin
      case ($urandom_range(19, 0))
        0: t = 32'h0;
        1: t = 32'hFFFFFFFF;
        2: t = hi;
        3: t = lo;
        4: t = $urandom();
        5: begin
          // noise: stray writes, no-ops, disordered knot
          push(req_e'($urandom_range(3, 0)), $urandom_range(127, 0), $urandom(),
               $urandom(), $urandom(), $urandom(), $urandom());
          t = $urandom_range(hi, lo);
        end
        default: t = $urandom_range(hi, lo);
      endcase
      push(REQ_EVAL, $urandom_range(127, 0), $urandom(), $urandom(), $urandom(),
           $urandom(), t);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    // directed: empty curve, no-op, ignored slots
    push(REQ_EVAL, 0, 0, 0, 0, 0, 32'h10000);
    push(REQ_NOP, 0, 32'hFFFFFFFF, 0, 0, 0, 0);
    push(REQ_POINT, 64, 32'h1, 32'h1, 32'h1, 32'h1, 0);
    push(REQ_POINT, 127, 32'h1, 32'h1, 32'h1, 32'h1, 0);
    push(REQ_KNOT, 72, 0, 0, 0, 0, 32'hFFFFFFFF);
    push(REQ_KNOT, 127, 0, 0, 0, 0, 32'h1);
    // fill every store entry so nothing is read unwritten
    for (int i = 0; i < KNOT_DEPTH; i++)
      push(REQ_KNOT, i, 0, 0, 0, 0, i * 32'h10000);
    push(REQ_KNOT, KNOT_DEPTH - 1, 0, 0, 0, 0, 32'hFFFFFFFF);
    for (int i = 0; i < MAX_POINTS; i++)
      push(REQ_POINT, i, $urandom(), $urandom(), $urandom(), 32'h10000, 0);
    push(REQ_POINT, 0, 32'h80000000, 32'h7FFFFFFF, 32'h0, 32'hFFFFFFFF, 0);
    push(REQ_POINT, 1, 32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF, 32'h0, 0);
    push(REQ_POINT, 2, 32'h0, 32'h0, 32'h0, 32'h0, 0);
    push(REQ_EVAL, 0, 0, 0, 0, 0, 32'h0);
    push(REQ_EVAL, 0, 0, 0, 0, 0, 32'h18000);
    push(REQ_EVAL, 0, 0, 0, 0, 0, 32'hFFFFFFFF);

    idle_mode = 0;
    run_phase(7, 64, 40, 0);
    run_phase(0, 1, 60, 0);
    run_phase(1, 100, 200, 1);
    run_phase(3, 8, 250, 0);
    idle_mode = 1;
    run_phase(2, 5, 250, 0);
    run_phase(7, 9, 80, 0);
    run_phase(3, 2, 200, 0);
    idle_mode = 2;
    run_phase(1, 3, 250, 0);
    run_phase(5, 20, 120, 0);
    run_phase(3, 0, 40, 0);
    run_phase(2, 12, 250, 0);
    drain();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && expected_points.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #400ms;
    $display("TEST FAILED");
    $finish;
  end
endmodule
